>>> hdl/register_vm_instruction_executor_assert.svh
// ============================================================================
// Assertion macros for the register VM instruction executor
// Shorthand for concurrent assertions that report through $error.
// ============================================================================
`ifndef REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define REGISTER_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Check a property at each rising edge outside reset.
`define RVIE_ASSERT(lbl, clk, rstn, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check a property at each rising edge, reset included.
`define RVIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/rvie_pkg.sv
// ============================================================================
// rvie_pkg
// Types and constants shared by the executor's controller and datapath.
// ============================================================================
package rvie_pkg;

	localparam int CMD_W  = 4;
	localparam int IDX_W  = 12;
	localparam int IMM_W  = 64;
	localparam int CHAR_W = 8;
	localparam int IN_W   = 184;   // 182 field bits, padded to bytes
	localparam int OUT_W  = 80;    // 77 field bits, padded to bytes

	typedef enum logic [CMD_W-1:0] {
		CMD_NOP   = 4'd0,
		CMD_MOVE  = 4'd1,
		CMD_ADD   = 4'd2,
		CMD_SUB   = 4'd3,
		CMD_MUL   = 4'd4,
		CMD_DIV   = 4'd5,
		CMD_MOD   = 4'd6,
		CMD_OUT   = 4'd7,
		CMD_BOOL  = 4'd8,
		CMD_LESS  = 4'd9,
		CMD_EQUAL = 4'd10,
		CMD_RET   = 4'd11
	} cmd_t;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_RDA   = 9'b000000100,
		ST_RDB   = 9'b000001000,
		ST_OPB   = 9'b000010000,
		ST_EXEC  = 9'b000100000,
		ST_MUL   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic rd_a;
		logic cap_a;
		logic rd_b;
		logic cap_b;
		logic mul_init;
		logic mul_step;
		logic div_init;
		logic div_step;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_mul;
		logic is_div;
		logic b_zero;
		logic mul_last;
		logic div_last;
		logic out_free;
	} dp_stat_t;

endpackage

>>> hdl/register_vm_instruction_executor.sv
// ============================================================================
// register_vm_instruction_executor
// Executes one decoded register-machine instruction per item against a
// windowed register file of signed integers.
// ============================================================================
//
//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one decoded instruction (s_tdata)
//  m_*      | out | m_tvalid/m_tready  | one result per instruction (m_tdata)
//
//  Move, add, sub, out, branches, ret, nop and a divide by zero go from
//  the operand reads straight to the hand-off; mul adds three partial
//  products on one half-width multiplier; div and mod add one quotient
//  bit a cycle. The single read port of the register file reads the two
//  operands one after the other. After reset the register file is swept
//  to zero, entry by entry, with s_tready low.
//  A result waits in the output register; the next item is taken meanwhile
//  and only its hand-off stalls while m_tready stays low.
//
module register_vm_instruction_executor #(
	parameter int REG_COUNT   = 4096,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// command[3:0], frame_base[15:4], dest_reg[27:16], a_is_reg[28],
	// a_reg[40:29], a_imm[104:41], b_is_reg[105], b_reg[117:106],
	// b_imm[181:118], zero pad[183:182]
	input  logic [rvie_pkg::IN_W-1:0]   s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// result_value[63:0], wrote_reg[64], branch_taken[65], char_valid[66],
	// char_out[74:67], div_zero[75], is_return[76], zero pad[79:77]
	output logic [rvie_pkg::OUT_W-1:0]  m_tdata
);
	import rvie_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequence the item through read, execute and hand-off
	rvie_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// hold operands, register file, arithmetic units and the output item
	rvie_dp #(
		.REG_COUNT   (REG_COUNT),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

>>> hdl/rvie_ram.sv
// ============================================================================
// rvie_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module rvie_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/rvie_ctrl.sv
// ============================================================================
// rvie_ctrl
// Sequencer: clearing pass, operand reads, multi-cycle units, result hand-off.
// ============================================================================
module rvie_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  rvie_pkg::dp_stat_t    stat,
	output rvie_pkg::ctrl_cmd_t   cmd
);
	import rvie_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RDA;
				end
			end
			ST_RDA: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_RDB;
			end
			ST_RDB: begin
				cmd.cap_a = 1'b1;
				cmd.rd_b  = 1'b1;
				state_d   = ST_OPB;
			end
			ST_OPB: begin
				cmd.cap_b = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				if (stat.is_mul) begin
					cmd.mul_init = 1'b1;
					state_d      = ST_MUL;
				end else if (stat.is_div && !stat.b_zero) begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (stat.mul_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

>>> hdl/rvie_dp.sv
// ============================================================================
// rvie_dp
// Datapath: item registers, register file, shared multiplier, divider, output.
// ============================================================================
module rvie_dp #(
	parameter int REG_COUNT   = 4096,
	parameter int VALUE_WIDTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rvie_pkg::ctrl_cmd_t           cmd,
	output rvie_pkg::dp_stat_t            stat,
	input  logic [rvie_pkg::IN_W-1:0]     in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rvie_pkg::OUT_W-1:0]    out_data
);
	import rvie_pkg::*;

	localparam int AW  = $clog2(REG_COUNT);
	localparam int VW  = VALUE_WIDTH;
	localparam int HW  = (VW + 1) / 2;
	localparam int PW  = 2 * HW;
	localparam int DCW = $clog2(VW);

	// item fields
	cmd_t              cmd_q;
	logic [IDX_W-1:0]  base_q, dest_q, a_reg_q, b_reg_q;
	logic              a_is_reg_q, b_is_reg_q;
	logic [VW-1:0]     a_imm_q, b_imm_q;
	logic [VW-1:0]     a_q, b_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q      <= cmd_t'(in_data[3:0]);
			base_q     <= in_data[15:4];
			dest_q     <= in_data[27:16];
			a_is_reg_q <= in_data[28];
			a_reg_q    <= in_data[40:29];
			a_imm_q    <= in_data[41 +: VW];
			b_is_reg_q <= in_data[105];
			b_reg_q    <= in_data[117:106];
			b_imm_q    <= in_data[118 +: VW];
		end
	end

	// window-relative register indexes
	logic [IDX_W:0]  a_sum, b_sum, d_sum;
	logic [AW-1:0]   a_idx, b_idx, d_idx;

	assign a_sum = {1'b0, base_q} + {1'b0, a_reg_q};
	assign b_sum = {1'b0, base_q} + {1'b0, b_reg_q};
	assign d_sum = {1'b0, base_q} + {1'b0, dest_q};
	assign a_idx = AW'(a_sum % REG_COUNT);
	assign b_idx = AW'(b_sum % REG_COUNT);
	assign d_idx = AW'(d_sum % REG_COUNT);

	// register file and clearing pass
	logic [AW-1:0] clr_idx_q;
	logic          rf_we;
	logic [AW-1:0] rf_waddr, rf_raddr;
	logic [VW-1:0] rf_wdata, rf_rdata;
	logic [VW-1:0] res_c;
	logic          wr_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_step) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	assign rf_we    = cmd.clr_step | (cmd.finish & wr_c);
	assign rf_waddr = cmd.clr_step ? clr_idx_q : d_idx;
	assign rf_wdata = cmd.clr_step ? '0 : res_c;
	assign rf_raddr = cmd.rd_b ? b_idx : a_idx;

	rvie_ram #(
		.WIDTH (VW),
		.DEPTH (REG_COUNT)
	) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.cap_a) begin
			a_q <= a_is_reg_q ? rf_rdata : a_imm_q;
		end
		if (cmd.cap_b) begin
			b_q <= b_is_reg_q ? rf_rdata : b_imm_q;
		end
	end

	// multiplier: three half-width partial products on one unit
	logic [PW-1:0] a_x, b_x, prod, addend;
	logic [HW-1:0] m1, m2;
	logic [1:0]    mcnt_q;
	logic [VW-1:0] acc_q;

	assign a_x = PW'(a_q);
	assign b_x = PW'(b_q);

	always_comb begin
		case (mcnt_q)
			2'd0: begin
				m1 = a_x[HW-1:0];
				m2 = b_x[HW-1:0];
			end
			2'd1: begin
				m1 = a_x[HW-1:0];
				m2 = b_x[PW-1:HW];
			end
			default: begin
				m1 = a_x[PW-1:HW];
				m2 = b_x[HW-1:0];
			end
		endcase
		prod   = m1 * m2;
		addend = (mcnt_q == 2'd0) ? prod : (prod << HW);
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			mcnt_q <= 2'd0;
			acc_q  <= '0;
		end else if (cmd.mul_step) begin
			mcnt_q <= mcnt_q + 2'd1;
			acc_q  <= acc_q + VW'(addend);
		end
	end

	// divider: restoring, one quotient bit per cycle on magnitudes
	logic          a_neg, b_neg;
	logic [VW-1:0] ua, ub;
	logic [VW-1:0] rem_q, quo_q;
	logic [DCW-1:0] dcnt_q;
	logic [VW:0]   dsh, ddiff;

	assign a_neg = a_q[VW-1];
	assign b_neg = b_q[VW-1];
	assign ua    = a_neg ? (VW'(0) - a_q) : a_q;
	assign ub    = b_neg ? (VW'(0) - b_q) : b_q;
	assign dsh   = {rem_q, quo_q[VW-1]};
	assign ddiff = dsh - {1'b0, ub};

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= ua;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DCW'(1);
			if (!ddiff[VW]) begin
				rem_q <= ddiff[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= dsh[VW-1:0];
				quo_q <= {quo_q[VW-2:0], 1'b0};
			end
		end
	end

	// result
	logic              taken_c, cv_c, dz_c, ret_c;
	logic [CHAR_W-1:0] cout_c;
	logic              b_zero;

	assign b_zero = (b_q == '0);

	always_comb begin
		res_c   = '0;
		wr_c    = 1'b0;
		taken_c = 1'b0;
		cv_c    = 1'b0;
		cout_c  = '0;
		dz_c    = 1'b0;
		ret_c   = 1'b0;
		case (cmd_q)
			CMD_MOVE: begin
				res_c = a_q;
				wr_c  = 1'b1;
			end
			CMD_ADD: begin
				res_c = a_q + b_q;
				wr_c  = 1'b1;
			end
			CMD_SUB: begin
				res_c = a_q - b_q;
				wr_c  = 1'b1;
			end
			CMD_MUL: begin
				res_c = acc_q;
				wr_c  = 1'b1;
			end
			CMD_DIV: begin
				if (b_zero) begin
					dz_c = 1'b1;
				end else begin
					res_c = (a_neg != b_neg) ? (VW'(0) - quo_q) : quo_q;
					wr_c  = 1'b1;
				end
			end
			CMD_MOD: begin
				if (b_zero) begin
					dz_c = 1'b1;
				end else begin
					res_c = a_neg ? (VW'(0) - rem_q) : rem_q;
					wr_c  = 1'b1;
				end
			end
			CMD_OUT: begin
				cv_c   = 1'b1;
				cout_c = a_q[CHAR_W-1:0];
			end
			CMD_BOOL:  taken_c = (a_q != '0);
			CMD_LESS:  taken_c = ($signed(a_q) < $signed(b_q));
			CMD_EQUAL: taken_c = (a_q == b_q);
			CMD_RET: begin
				res_c = a_q;
				ret_c = 1'b1;
			end
			default: ;
		endcase
	end

	// output register
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q <= {3'b000, ret_c, dz_c, cout_c, cv_c, taken_c, wr_c,
				IMM_W'($signed(res_c))};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign stat.clr_last = (clr_idx_q == AW'(REG_COUNT - 1));
	assign stat.is_mul   = (cmd_q == CMD_MUL);
	assign stat.is_div   = (cmd_q == CMD_DIV) || (cmd_q == CMD_MOD);
	assign stat.b_zero   = b_zero;
	assign stat.mul_last = (mcnt_q == 2'd2);
	assign stat.div_last = (dcnt_q == DCW'(VW - 1));
	assign stat.out_free = !out_valid_q || out_ready;

endmodule

>>> hdl/rvie_chk.sv
// ============================================================================
// rvie_chk
// Port-level checks on the executor's result stream.
// ============================================================================
`include "register_vm_instruction_executor_assert.svh"

module rvie_chk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [rvie_pkg::OUT_W-1:0]  m_tdata
);

	`RVIE_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result item changed while stalled")
	`RVIE_ASSERT(a_no_write_on_dz, clk, arst_n, m_tvalid && m_tdata[75] |-> !m_tdata[64] && m_tdata[63:0] == 64'd0, "zero divisor with a write or a value")
	`RVIE_ASSERT(a_ret_alone, clk, arst_n, m_tvalid && m_tdata[76] |-> !m_tdata[64] && !m_tdata[66] && !m_tdata[65], "return mixed with other effects")
	`RVIE_ASSERT(a_char_zero, clk, arst_n, m_tvalid && !m_tdata[66] |-> m_tdata[74:67] == 8'd0, "character byte set without a character")
	`RVIE_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_tvalid, "result valid during reset")

endmodule

bind register_vm_instruction_executor rvie_chk u_chk (.*);
